// ===== src/rbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants of the reconnect backoff policy unit
// command and phase codes, register map, state and result records
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [31:0] FIRST_INTERVAL_RST = 32'd1000;
  localparam logic [31:0] MAX_INTERVAL_RST   = 32'd60000;
  localparam logic [7:0]  AP_THRESHOLD_RST   = 8'd3;
  localparam logic [7:0]  FAILURES_SAT       = 8'd255;

  typedef enum logic [2:0] {
    CMD_SET_PROV  = 3'd0,
    CMD_ATTEMPT   = 3'd1,
    CMD_CONNECTED = 3'd2,
    CMD_FAILED    = 3'd3,
    CMD_QUERY     = 3'd4
  } rbp_cmd_e;

  typedef enum logic [1:0] {
    REG_FIRST_INTERVAL = 2'd0,
    REG_MAX_INTERVAL   = 2'd1,
    REG_AP_THRESHOLD   = 2'd2
  } rbp_reg_e;

  // phase kept one-hot inside, reported as a 2-bit code
  typedef enum logic [3:0] {
    PH_UNPROV     = 4'b0001,
    PH_BACKOFF    = 4'b0010,
    PH_CONNECTING = 4'b0100,
    PH_CONNECTED  = 4'b1000
  } rbp_phase_e;

  localparam logic [1:0] PH_CODE_UNPROV     = 2'd0;
  localparam logic [1:0] PH_CODE_BACKOFF    = 2'd1;
  localparam logic [1:0] PH_CODE_CONNECTING = 2'd2;
  localparam logic [1:0] PH_CODE_CONNECTED  = 2'd3;

  typedef struct packed {
    logic [31:0] first_interval_ms;
    logic [31:0] max_interval_ms;
    logic [7:0]  ap_failure_threshold;
  } rbp_cfg_t;

  typedef struct packed {
    logic        is_provisioned;
    rbp_phase_e  phase;
    logic [7:0]  failures;
    logic [31:0] interval_ms;
    logic [31:0] interval_start_ms;
  } rbp_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        provisioned_flag;
    logic [31:0] now_ms;
    logic [7:0]  guest_count;
  } rbp_item_t;

  typedef struct packed {
    logic        may_attempt;
    logic [31:0] wait_left_ms;
    logic        open_ap;
    logic [1:0]  phase_now;
    logic [7:0]  failure_count;
  } rbp_result_t;

  function automatic logic [1:0] phase_code(rbp_phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_UNPROV:     code = PH_CODE_UNPROV;
      PH_BACKOFF:    code = PH_CODE_BACKOFF;
      PH_CONNECTING: code = PH_CODE_CONNECTING;
      PH_CONNECTED:  code = PH_CODE_CONNECTED;
      default:       code = PH_CODE_UNPROV;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/rbp_policy.sv =====
// ----------------------------------------------------------------------------
// rbp_policy: one-event state update and result computation
// applies an event to the policy state and derives the beat reported for it
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_policy import rbp_pkg::*; (
  input  wire rbp_cfg_t   cfg_i,
  input  wire rbp_state_t state_i,
  input  wire rbp_item_t  item_i,
  output rbp_state_t  state_o,
  output rbp_result_t result_o
);

  rbp_state_t  nxt;
  logic [32:0] dbl;
  logic [31:0] first_eff;
  logic [31:0] waited;
  logic        reached;
  logic        busy;
  logic        guest_block;
  logic        go;

  assign dbl       = {state_i.interval_ms, 1'b0};
  assign first_eff = (cfg_i.first_interval_ms == '0) ? 32'd1 : cfg_i.first_interval_ms;

  always_comb begin
    nxt = state_i;
    case (rbp_cmd_e'(item_i.cmd))
      CMD_SET_PROV: begin
        nxt.is_provisioned = item_i.provisioned_flag;
        nxt.failures       = '0;
        nxt.interval_ms    = '0;
        if (!item_i.provisioned_flag) begin
          nxt.phase = PH_UNPROV;
        end else begin
          nxt.interval_start_ms = '0;
          if (state_i.phase != PH_CONNECTING && state_i.phase != PH_CONNECTED) begin
            nxt.phase = PH_BACKOFF;
          end
        end
      end
      CMD_ATTEMPT: begin
        if (state_i.is_provisioned) begin
          nxt.phase = PH_CONNECTING;
        end
      end
      CMD_CONNECTED: begin
        nxt.phase       = PH_CONNECTED;
        nxt.failures    = '0;
        nxt.interval_ms = '0;
      end
      CMD_FAILED: begin
        if (state_i.is_provisioned) begin
          if (state_i.failures != FAILURES_SAT) begin
            nxt.failures = state_i.failures + 8'd1;
          end
          if (state_i.interval_ms == '0) begin
            nxt.interval_ms = first_eff;
          end else if (state_i.interval_ms < cfg_i.max_interval_ms) begin
            // 33-bit double catches the wrap past 32 bits as well
            nxt.interval_ms = (dbl > {1'b0, cfg_i.max_interval_ms}) ?
                              cfg_i.max_interval_ms : dbl[31:0];
          end
          nxt.interval_start_ms = item_i.now_ms;
          nxt.phase             = PH_BACKOFF;
        end
      end
      default: begin
        // query only, unused codes too
      end
    endcase
  end

  assign waited      = item_i.now_ms - nxt.interval_start_ms;
  assign reached     = (waited >= nxt.interval_ms);
  assign busy        = (nxt.phase == PH_CONNECTING) || (nxt.phase == PH_CONNECTED);
  assign guest_block = (item_i.guest_count != '0) && (nxt.failures != '0);
  assign go          = nxt.is_provisioned && !busy && !guest_block && reached;

  always_comb begin
    result_o.may_attempt   = go;
    result_o.wait_left_ms  = (go || reached) ? '0 : (nxt.interval_ms - waited);
    if (!nxt.is_provisioned) begin
      result_o.open_ap = 1'b1;
    end else if (nxt.phase == PH_CONNECTED) begin
      result_o.open_ap = 1'b0;
    end else begin
      result_o.open_ap = (nxt.failures >= cfg_i.ap_failure_threshold);
    end
    result_o.phase_now     = phase_code(nxt.phase);
    result_o.failure_count = nxt.failures;
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// ===== src/reconnect_backoff_policy_unit.sv =====
// ----------------------------------------------------------------------------
// reconnect_backoff_policy_unit: capped exponential backoff retry policy
// event-driven reconnect policy with apb configuration and valid/ready beats
// ----------------------------------------------------------------------------
// One event beat in, one result beat out. Events are taken at one per clock
// cycle unless the input stalls; each event is held in an input register and
// its result in a result register, and the whole event, state update
// included, is resolved by the policy logic between those two registers, so
// back-to-back events see each other's state changes with no bubble. The
// input register keeps accepting while a finished result waits on the output
// side, and stalls only when both registers are full and the result is not
// being taken. Configuration lives behind a small apb port: first interval at
// 0x0, interval cap at 0x4, access point failure threshold at 0x8; writes take
// effect for events that arrive after them and should be made while no beat
// is in flight.
`default_nettype none

module reconnect_backoff_policy_unit import rbp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // event channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            cmd_i,
  input  wire logic                  provisioned_flag_i,
  input  wire logic [31:0]           now_ms_i,
  input  wire logic [7:0]            guest_count_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       may_attempt_o,
  output logic      [31:0]           wait_left_ms_o,
  output logic                       open_ap_o,
  output logic      [1:0]            phase_now_o,
  output logic      [7:0]            failure_count_o
);

  // configuration registers
  rbp_cfg_t    cfg_q;
  logic        cfg_wr;
  rbp_reg_e    reg_sel;

  // pipeline
  logic        in_vld_q;
  rbp_item_t   in_item_q;
  logic        out_vld_q;
  rbp_result_t res_q;
  logic        advance;

  // policy state
  rbp_state_t  state_q;
  rbp_state_t  state_d;
  rbp_result_t res_d;

  // ------------------------------------------------------------------------
  // apb register file
  // ------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = rbp_reg_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_interval_ms    <= FIRST_INTERVAL_RST;
      cfg_q.max_interval_ms      <= MAX_INTERVAL_RST;
      cfg_q.ap_failure_threshold <= AP_THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FIRST_INTERVAL: cfg_q.first_interval_ms    <= pwdata;
        REG_MAX_INTERVAL:   cfg_q.max_interval_ms      <= pwdata;
        REG_AP_THRESHOLD:   cfg_q.ap_failure_threshold <= pwdata[7:0];
        default: begin
          // address past the map, write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FIRST_INTERVAL: prdata = cfg_q.first_interval_ms;
      REG_MAX_INTERVAL:   prdata = cfg_q.max_interval_ms;
      REG_AP_THRESHOLD:   prdata = {24'd0, cfg_q.ap_failure_threshold};
      default:            prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------------
  // handshake: the input stage moves on whenever the result slot is free or
  // being drained this cycle
  // ------------------------------------------------------------------------
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.cmd              <= cmd_i;
      in_item_q.provisioned_flag <= provisioned_flag_i;
      in_item_q.now_ms           <= now_ms_i;
      in_item_q.guest_count      <= guest_count_i;
    end
  end

  // ------------------------------------------------------------------------
  // policy logic: state update and result for the registered event
  // ------------------------------------------------------------------------
  rbp_policy u_policy (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.is_provisioned    <= 1'b0;
      state_q.phase             <= PH_UNPROV;
      state_q.failures          <= '0;
      state_q.interval_ms       <= '0;
      state_q.interval_start_ms <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign may_attempt_o   = res_q.may_attempt;
  assign wait_left_ms_o  = res_q.wait_left_ms;
  assign open_ap_o       = res_q.open_ap;
  assign phase_now_o     = res_q.phase_now;
  assign failure_count_o = res_q.failure_count;

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a permitted attempt never comes with time still left to wait
  a_go_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.may_attempt |-> res_q.wait_left_ms == '0)
    else $error("may_attempt beat with nonzero wait");

  // no attempt is granted while connecting or connected
  a_go_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.may_attempt |->
      res_q.phase_now != PH_CODE_CONNECTING && res_q.phase_now != PH_CODE_CONNECTED)
    else $error("may_attempt beat in a busy phase");

  // an event in the input register moves on unless the result slot is stalled
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !(out_vld_q && !out_ready_i) |=> out_vld_q)
    else $error("input beat did not reach the result register");
`endif

endmodule

`default_nettype wire

// ===== tb/reconnect_backoff_policy_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reconnect_backoff_policy_unit_test: self-checking bench for the backoff unit
// drives event beats under random gaps and back-pressure, predicts each result
// beat from a local copy of the policy state and compares field by field
// ----------------------------------------------------------------------------

module reconnect_backoff_policy_unit_test;
  import rbp_pkg::*;

  localparam int unsigned HALF_PERIOD      = 5;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned WATCHDOG_LIMIT   = 1000;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned HOLD_OFF_CYCLES  = 40;
  localparam int unsigned RANDOM_ROUNDS    = 5;
  localparam int unsigned EVENTS_PER_ROUND = 20;
  localparam int unsigned SATURATION_FAILS = 258;

  // command codes outside the defined set, handled as a plain query
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  // apb configuration port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // event channel
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic        provisioned_flag_i;
  logic [31:0] now_ms_i;
  logic [7:0]  guest_count_i;

  // result channel
  logic        out_valid_o;
  logic        out_ready_i;
  logic        may_attempt_o;
  logic [31:0] wait_left_ms_o;
  logic        open_ap_o;
  logic [1:0]  phase_now_o;
  logic [7:0]  failure_count_o;

  // policy registers as the bench believes them to be
  logic [31:0] pol_first_ms;
  logic [31:0] pol_max_ms;
  logic [7:0]  pol_ap_threshold;

  // local copy of the policy state
  logic        st_provisioned;
  logic [1:0]  st_phase;
  logic [7:0]  st_failures;
  logic [31:0] st_interval_ms;
  logic [31:0] st_interval_start_ms;

  // results owed by the block, oldest first
  rbp_result_t expected_q[$];

  int unsigned mismatches  = 0;
  int unsigned result_beat = 0;
  int unsigned idle_cycles = 0;

  // idling controls shared by the tests and the result sink
  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  int unsigned sink_hold = 0;

  // free-running millisecond clock seen by the random traffic
  logic [31:0] sim_now_ms = 32'd0;

  reconnect_backoff_policy_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .provisioned_flag_i (provisioned_flag_i),
    .now_ms_i           (now_ms_i),
    .guest_count_i      (guest_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .may_attempt_o      (may_attempt_o),
    .wait_left_ms_o     (wait_left_ms_o),
    .open_ap_o          (open_ap_o),
    .phase_now_o        (phase_now_o),
    .failure_count_o    (failure_count_o)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // policy predictor: applies one event to the local state, returns the result
  // --------------------------------------------------------------------------
  function automatic rbp_result_t predict_policy(rbp_item_t ev);
    rbp_result_t res;
    logic [32:0] doubled;
    logic [31:0] waited;
    logic        go;

    case (ev.cmd)
      CMD_SET_PROV: begin
        st_provisioned = ev.provisioned_flag;
        st_failures    = 8'd0;
        st_interval_ms = 32'd0;
        if (!ev.provisioned_flag) begin
          // withdrawn: start time survives
          st_phase = PH_CODE_UNPROV;
        end else begin
          st_interval_start_ms = 32'd0;
          if (st_phase != PH_CODE_CONNECTING && st_phase != PH_CODE_CONNECTED) begin
            st_phase = PH_CODE_BACKOFF;
          end
        end
      end
      CMD_ATTEMPT: begin
        if (st_provisioned) begin
          st_phase = PH_CODE_CONNECTING;
        end
      end
      CMD_CONNECTED: begin
        // takes effect even while unprovisioned
        st_phase       = PH_CODE_CONNECTED;
        st_failures    = 8'd0;
        st_interval_ms = 32'd0;
      end
      CMD_FAILED: begin
        if (st_provisioned) begin
          if (st_failures != FAILURES_SAT) begin
            st_failures = st_failures + 8'd1;
          end
          if (st_interval_ms == 32'd0) begin
            st_interval_ms = (pol_first_ms == 32'd0) ? 32'd1 : pol_first_ms;
          end else if (st_interval_ms < pol_max_ms) begin
            // a double past the cap or past 32 bits lands on the cap
            doubled = {st_interval_ms, 1'b0};
            st_interval_ms = (doubled > {1'b0, pol_max_ms}) ? pol_max_ms : doubled[31:0];
          end
          st_interval_start_ms = ev.now_ms;
          st_phase             = PH_CODE_BACKOFF;
        end
      end
      default: begin
        // query and spare codes leave the state alone
      end
    endcase

    waited = ev.now_ms - st_interval_start_ms;
    go = st_provisioned && st_phase != PH_CODE_CONNECTING && st_phase != PH_CODE_CONNECTED
         && !(ev.guest_count != 8'd0 && st_failures != 8'd0) && waited >= st_interval_ms;

    res.may_attempt   = go;
    res.wait_left_ms  = (go || waited >= st_interval_ms) ? 32'd0 : st_interval_ms - waited;
    if (!st_provisioned) begin
      res.open_ap = 1'b1;
    end else if (st_phase == PH_CODE_CONNECTED) begin
      res.open_ap = 1'b0;
    end else begin
      res.open_ap = st_failures >= pol_ap_threshold;
    end
    res.phase_now     = st_phase;
    res.failure_count = st_failures;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // event sender: one beat, with an optional idle burst ahead of it
  // returns at the rising edge that took the beat
  // --------------------------------------------------------------------------
  task automatic send_event(input logic [2:0] code, input logic flag,
                            input logic [31:0] now, input logic [7:0] guests);
    rbp_item_t ev;
    ev.cmd              = code;
    ev.provisioned_flag = flag;
    ev.now_ms           = now;
    ev.guest_count      = guests;
    @(negedge clk_i);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= ev.cmd;
    provisioned_flag_i <= ev.provisioned_flag;
    now_ms_i           <= ev.now_ms;
    guest_count_i      <= ev.guest_count;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_policy(ev));
  endtask

  // random event, weighted toward provisioned retry traffic; the time often
  // lands right at the end of the running backoff interval
  task automatic send_random_event();
    logic [2:0]  code;
    logic        flag;
    logic [7:0]  guests;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      code = CMD_SET_PROV;
    end else if (pick < 28) begin
      code = CMD_ATTEMPT;
    end else if (pick < 36) begin
      code = CMD_CONNECTED;
    end else if (pick < 64) begin
      code = CMD_FAILED;
    end else if (pick < 95) begin
      code = CMD_QUERY;
    end else begin
      code = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    end
    // mostly provisioning given, otherwise the flag is noise
    flag = (code == CMD_SET_PROV) ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: sim_now_ms = sim_now_ms + $urandom_range(0, 20);
      4, 5, 6:    sim_now_ms = st_interval_start_ms + st_interval_ms + $urandom_range(0, 4) - 2;
      7, 8:       sim_now_ms = sim_now_ms + $urandom_range(0, 100000);
      default:    sim_now_ms = $urandom();
    endcase
    guests = ($urandom_range(0, 9) < 6) ? 8'd0 : 8'($urandom_range(1, 255));
    send_event(code, flag, sim_now_ms, guests);
  endtask

  // drop valid and wait until every owed result has been taken
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_policy_reg(input rbp_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FIRST_INTERVAL: pol_first_ms     = value;
      REG_MAX_INTERVAL:   pol_max_ms       = value;
      REG_AP_THRESHOLD:   pol_ap_threshold = value[7:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_policy(input logic [31:0] first_ms, input logic [31:0] max_ms,
                            input logic [7:0] threshold);
    drain_results();
    write_policy_reg(REG_FIRST_INTERVAL, first_ms);
    write_policy_reg(REG_MAX_INTERVAL, max_ms);
    write_policy_reg(REG_AP_THRESHOLD, {24'd0, threshold});
  endtask

  function automatic logic [31:0] random_interval();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8);
      1:       return $urandom_range(9, 5000);
      2:       return $urandom_range(5001, 1000000);
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset values, every command, unprovisioned handling, guests and wraparound
  task automatic test_reset_defaults();
    send_event(CMD_QUERY,     1'b0, 32'd0,        8'd0);
    // attempt and failure mean nothing while unprovisioned
    send_event(CMD_ATTEMPT,   1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_event(CMD_FAILED,    1'b1, 32'h0000_1234, 8'd0);
    send_event(CMD_SPARE_A,   1'b1, 32'h8000_0000, 8'd1);
    send_event(CMD_SPARE_B,   1'b0, 32'h7FFF_FFFF, 8'h80);
    send_event(CMD_SPARE_C,   1'b1, 32'h5555_5555, 8'h55);
    // connected sticks even unprovisioned, and provisioning keeps it
    send_event(CMD_CONNECTED, 1'b0, 32'd10,       8'd0);
    send_event(CMD_SET_PROV,  1'b1, 32'd20,       8'd0);
    send_event(CMD_ATTEMPT,   1'b0, 32'd30,       8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd100,      8'd0);
    // first interval: mid way, one short, exactly over
    send_event(CMD_QUERY,     1'b0, 32'd600,      8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd1099,     8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd1100,     8'd0);
    // guests attached with failures on record block the retry
    send_event(CMD_QUERY,     1'b1, 32'd1100,     8'd255);
    send_event(CMD_FAILED,    1'b0, 32'hFFFF_FF00, 8'd3);
    send_event(CMD_QUERY,     1'b0, 32'h0000_0100, 8'd0);
    // third failure reaches the default threshold
    send_event(CMD_FAILED,    1'b0, 32'hFFFF_FF80, 8'd0);
    send_event(CMD_QUERY,     1'b0, 32'hFFFF_FF80 + 32'd3999, 8'd0);
    send_event(CMD_QUERY,     1'b0, 32'hFFFF_FF80 + 32'd4000, 8'd0);
    // withdrawn keeps the start, given clears it
    send_event(CMD_SET_PROV,  1'b0, 32'd5,        8'd7);
    send_event(CMD_QUERY,     1'b0, 32'd6,        8'd7);
    send_event(CMD_SET_PROV,  1'b1, 32'd9,        8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd0,        8'd255);
    send_event(CMD_CONNECTED, 1'b1, 32'd50,       8'd0);
  endtask

  // register extremes: zero first interval, first above cap, doubling wrap
  task automatic test_register_extremes();
    set_policy(32'd0, 32'hFFFF_FFFF, 8'd0);
    send_event(CMD_SET_PROV,  1'b1, 32'd0,        8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd10,       8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd10,       8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd12,       8'd0);

    set_policy(32'd5000, 32'd0, 8'd255);
    send_event(CMD_SET_PROV,  1'b1, 32'd0,        8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd100,      8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd200,      8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd300,      8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd5299,     8'd0);

    set_policy(32'h8000_0001, 32'hFFFF_FFFF, 8'd2);
    send_event(CMD_SET_PROV,  1'b1, 32'd0,        8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd1,        8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd2,        8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd3,        8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd1,        8'd0);

    set_policy(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1);
    send_event(CMD_SET_PROV,  1'b1, 32'd0,        8'd0);
    send_event(CMD_FAILED,    1'b0, 32'd7,        8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd5,        8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd6,        8'd0);

    // 3, 6, 12, then clamped to 20 and held there
    set_policy(32'd3, 32'd20, 8'd4);
    send_event(CMD_SET_PROV,  1'b1, 32'd0,        8'd0);
    repeat (6) send_event(CMD_FAILED, 1'b0, 32'd40, 8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd59,       8'd0);
    send_event(CMD_QUERY,     1'b0, 32'd60,       8'd0);
  endtask

  // failure count runs into its ceiling, threshold at its top value
  task automatic test_failure_saturation();
    set_policy(32'd1, 32'd64, 8'd255);
    send_event(CMD_SET_PROV, 1'b1, sim_now_ms, 8'd0);
    repeat (SATURATION_FAILS) begin
      sim_now_ms = sim_now_ms + $urandom_range(0, 100);
      send_event(CMD_FAILED, 1'($urandom_range(0, 1)), sim_now_ms,
                 ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 255)));
    end
    send_event(CMD_QUERY, 1'b0, sim_now_ms + 32'd64, 8'd0);
  endtask

  // long receiver hold-off while beats keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_policy(32'd10, 32'd1000, 8'd3);
    src_gaps = 1'b0;
    send_event(CMD_SET_PROV, 1'b1, 32'd0, 8'd0);
    sink_hold = HOLD_OFF_CYCLES;
    repeat (16) send_random_event();
    src_gaps = 1'b1;
  endtask

  // sender goes quiet until the pipe is empty, then resumes
  task automatic test_sender_pause();
    repeat (8) send_random_event();
    drain_results();
    repeat (8) send_random_event();
  endtask

  // random rounds, each with its own register setting; the last one runs
  // with no idling on either side
  task automatic test_random_traffic();
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      set_policy(random_interval(), random_interval(),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
      if (r == RANDOM_ROUNDS - 1) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end
      send_event(CMD_SET_PROV, 1'b1, sim_now_ms, 8'd0);
      repeat (EVENTS_PER_ROUND) send_random_event();
    end
  endtask

  // --------------------------------------------------------------------------
  // result sink: random stall bursts, plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        out_ready_i <= 1'b0;
        sink_hold = sink_hold - 1;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left = stall_left - 1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result beat %0d: %s expected %0h, got %0h", result_beat, name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    rbp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result beat %0d: no result was owed", result_beat);
        end
      end else begin
        want = expected_q.pop_front();
        check_field("may_attempt",   32'(want.may_attempt),   32'(may_attempt_o));
        check_field("wait_left_ms",  want.wait_left_ms,       wait_left_ms_o);
        check_field("open_ap",       32'(want.open_ap),       32'(open_ap_o));
        check_field("phase_now",     32'(want.phase_now),     32'(phase_now_o));
        check_field("failure_count", 32'(want.failure_count), 32'(failure_count_o));
      end
      result_beat++;
    end
  end

  // watchdog: too long without any beat or register write means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results still owed", expected_q.size());
        $display("reconnect_backoff_policy_unit: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid_i         = 1'b0;
    cmd_i              = CMD_QUERY;
    provisioned_flag_i = 1'b0;
    now_ms_i           = 32'd0;
    guest_count_i      = 8'd0;

    // predictor starts from the reset values
    pol_first_ms         = FIRST_INTERVAL_RST;
    pol_max_ms           = MAX_INTERVAL_RST;
    pol_ap_threshold     = AP_THRESHOLD_RST;
    st_provisioned       = 1'b0;
    st_phase             = PH_CODE_UNPROV;
    st_failures          = 8'd0;
    st_interval_ms       = 32'd0;
    st_interval_start_ms = 32'd0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_failure_saturation();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    drain_results();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("reconnect_backoff_policy_unit: match");
    end else begin
      $display("reconnect_backoff_policy_unit: mismatch");
    end
    $finish;
  end

endmodule
